// ===== src/site_pkg.sv =====
// ----------------------------------------------------------------------------
// site_pkg
// Shared types, constants and helpers for the scroll interpolator with
// tile-edge refresh detection.
// ----------------------------------------------------------------------------
package site_pkg;

	// default parameter values
	localparam int PANES_DEF      = 2;
	localparam int TILE_SHIFT_DEF = 3;

	// fixed field widths
	localparam int POS_W   = 16;
	localparam int TIME_W  = 16;
	localparam int CLK_W   = 32;
	localparam int TILE_W  = 14;
	localparam int OFF_W   = 48;
	localparam int NUM_W   = 32;
	localparam int DEN_W   = 16;
	localparam int CIDX_W  = 2;

	// divider retires two quotient bits per cycle
	localparam int DIV_STEPS = NUM_W / 2;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_X_OFF = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_Y_OFF = 2'd1;

	// direction codes, also the byte index into an offset register
	localparam logic [1:0] DIR_DEC  = 2'd0;
	localparam logic [1:0] DIR_HOLD = 2'd1;
	localparam logic [1:0] DIR_INC  = 2'd2;

	// byte offset of the row offsets within an offset register
	localparam logic [2:0] ROW_BASE = 3'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef struct packed {
		logic              col_ref;
		logic [TILE_W-1:0] col_tx;
		logic [TILE_W-1:0] col_ty;
		logic              row_ref;
		logic [TILE_W-1:0] row_tx;
		logic [TILE_W-1:0] row_ty;
	} res_t;

	// signed byte k of a six-byte offset word
	function automatic logic signed [7:0] edge_off(input logic [OFF_W-1:0] word,
		input logic [2:0] k);
		edge_off = $signed(word[8*k +: 8]);
	endfunction

endpackage

// ===== src/scroll_interpolate_tile_edge.sv =====
// ----------------------------------------------------------------------------
// scroll_interpolate_tile_edge
// Pane scroll interpolator with tile-edge column/row refresh requests.
// ----------------------------------------------------------------------------
// Each input request steps one pane: the position is interpolated linearly
// from (from_x, from_y) to (to_x, to_y) over [begin_time, finish_time] and
// held at the end point once the scene clock reaches finish_time; a zero
// duration gives no displacement. The new 8-pixel tile (pos >>> TILE_SHIFT)
// is compared with the tile of the position last drawn for that pane, and a
// changed X tile raises a column refresh, a changed Y tile a row refresh, each
// at the new tile plus a signed edge offset picked by the direction of motion
// (byte 0..2 column, 3..5 row, indexed dec/hold/inc). Tile fields read zero
// when their refresh flag is clear. Both axes share one 32/16 divider that
// retires two quotient bits per cycle; each axis passes the multiply, divider
// start, divider wait and position states, then a tile state ends the request.
// The input is not ready while a request is in flight; a finished result
// waits in the output register and does not block the next request until
// its own tile cycle. Edge offsets are to be written on the cfg port while
// the block is idle, which it does not enforce; drawn positions reset to zero.
// ----------------------------------------------------------------------------
module scroll_interpolate_tile_edge #(
	parameter int PANES      = site_pkg::PANES_DEF,
	parameter int TILE_SHIFT = site_pkg::TILE_SHIFT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [site_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [site_pkg::OFF_W-1:0]    cfg_data,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] scene_clock, [47:32] begin_time, [63:48] finish_time,
	// [79:64] from_x, [95:80] from_y, [111:96] to_x, [127:112] to_y
	input  logic [127:0]                  s_tdata,
	// [0] pane
	input  logic                          s_tuser,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] pos_x, [31:16] pos_y, [32] column_refresh, [46:33] column_tile_x,
	// [60:47] column_tile_y, [61] row_refresh, [75:62] row_tile_x,
	// [89:76] row_tile_y, [95:90] zero
	output logic [95:0]                   m_tdata,
	// [0] pane_out
	output logic                          m_tuser
);

	localparam int PIDX_W = (PANES > 1) ? $clog2(PANES) : 1;

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_DSTART = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_POS    = 3'd4;
	localparam logic [2:0] ST_TILE   = 3'd5;

	localparam int PW = site_pkg::POS_W;

	logic [2:0]                    state_q;
	logic                          axis_q;

	// configuration
	logic [site_pkg::OFF_W-1:0]    x_off_q, y_off_q;

	// request payload
	logic                          pane_q;
	logic [site_pkg::TIME_W-1:0]   el_q, dur_q;
	logic [PW-1:0]                 from_x_q, from_y_q, to_x_q, to_y_q;

	// per-axis working registers
	logic [site_pkg::NUM_W-1:0]    prod_q;
	logic [1:0]                    dir_x_q, dir_y_q;
	logic [PW-1:0]                 pos_x_q, pos_y_q;

	// drawn positions per pane
	logic [PW-1:0]                 drawn_x_q [PANES];
	logic [PW-1:0]                 drawn_y_q [PANES];
	logic [PIDX_W-1:0]             pidx;

	// output register
	logic                          m_valid_q;
	logic                          out_pane_q;
	logic [PW-1:0]                 out_x_q, out_y_q;
	site_pkg::res_t                out_res_q;

	// combinational
	logic                          s_acc, m_acc;
	logic [site_pkg::CLK_W-1:0]    in_clock;
	logic [site_pkg::TIME_W-1:0]   in_begin, in_finish;
	logic [PW-1:0]                 ax_from, ax_to;
	logic [PW:0]                   dif_up, dif_dn;
	logic [1:0]                    ax_dir, cur_dir;
	logic [PW-1:0]                 dif_mag;
	logic                          neg;
	logic [site_pkg::NUM_W-1:0]    mag;
	logic                          div_start;
	site_pkg::div_sts_t            div_sts;
	logic [site_pkg::NUM_W-1:0]    div_quo;
	logic [PW-1:0]                 q_lo, new_pos;
	site_pkg::res_t                tile_res;
	logic                          out_free;

	assign in_clock  = s_tdata[31:0];
	assign in_begin  = s_tdata[47:32];
	assign in_finish = s_tdata[63:48];

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign m_acc     = m_valid_q && m_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign pidx = (PANES > 1) ? PIDX_W'(pane_q) : '0;

	// current axis operands and direction
	always_comb begin
		ax_from = axis_q ? from_y_q : from_x_q;
		ax_to   = axis_q ? to_y_q   : to_x_q;
		dif_up  = {ax_to[PW-1], ax_to} - {ax_from[PW-1], ax_from};
		dif_dn  = {ax_from[PW-1], ax_from} - {ax_to[PW-1], ax_to};
		if ($signed(ax_from) < $signed(ax_to)) begin
			ax_dir = site_pkg::DIR_INC;
		end else if ($signed(ax_from) > $signed(ax_to)) begin
			ax_dir = site_pkg::DIR_DEC;
		end else begin
			ax_dir = site_pkg::DIR_HOLD;
		end
		dif_mag = (ax_dir == site_pkg::DIR_INC) ? dif_up[PW-1:0] : dif_dn[PW-1:0];
		cur_dir = axis_q ? dir_y_q : dir_x_q;
	end

	// product is read as two's complement; divide its magnitude
	always_comb begin
		neg       = prod_q[site_pkg::NUM_W-1];
		mag       = neg ? (~prod_q + 1'b1) : prod_q;
		div_start = (state_q == ST_DSTART);
	end

	site_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag),
		.den    (dur_q),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	// only the low 16 bits of the quotient reach the position
	always_comb begin
		if (dur_q == '0) begin
			q_lo = '0;
		end else begin
			q_lo = neg ? (~div_quo[PW-1:0] + 1'b1) : div_quo[PW-1:0];
		end
		new_pos = (cur_dir == site_pkg::DIR_INC) ? (ax_from + q_lo) : (ax_from - q_lo);
	end

	site_tile #(
		.TILE_SHIFT (TILE_SHIFT)
	) u_tile (
		.pos_x   (pos_x_q),
		.pos_y   (pos_y_q),
		.drawn_x (drawn_x_q[pidx]),
		.drawn_y (drawn_y_q[pidx]),
		.dir_x   (dir_x_q),
		.dir_y   (dir_y_q),
		.x_off   (x_off_q),
		.y_off   (y_off_q),
		.res     (tile_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q <= '0;
			y_off_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				site_pkg::CFG_X_OFF: x_off_q <= cfg_data;
				site_pkg::CFG_Y_OFF: y_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_MUL;
						axis_q  <= 1'b0;
					end
				end
				ST_MUL:    state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					if (axis_q) begin
						state_q <= ST_TILE;
					end else begin
						axis_q  <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_TILE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture and per-axis datapath
	always_ff @(posedge clk) begin
		if (s_acc) begin
			pane_q   <= s_tuser;
			dur_q    <= in_finish - in_begin;
			el_q     <= (in_clock < {16'd0, in_finish}) ? (in_clock[15:0] - in_begin)
			                                            : (in_finish - in_begin);
			from_x_q <= s_tdata[79:64];
			from_y_q <= s_tdata[95:80];
			to_x_q   <= s_tdata[111:96];
			to_y_q   <= s_tdata[127:112];
		end
		if (state_q == ST_MUL) begin
			prod_q <= site_pkg::NUM_W'(el_q) * site_pkg::NUM_W'(dif_mag);
			if (axis_q) begin
				dir_y_q <= ax_dir;
			end else begin
				dir_x_q <= ax_dir;
			end
		end
		if (state_q == ST_POS) begin
			if (axis_q) begin
				pos_y_q <= new_pos;
			end else begin
				pos_x_q <= new_pos;
			end
		end
	end

	// drawn positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PANES; i++) begin
				drawn_x_q[i] <= '0;
				drawn_y_q[i] <= '0;
			end
		end else if (state_q == ST_TILE && out_free) begin
			drawn_x_q[pidx] <= pos_x_q;
			drawn_y_q[pidx] <= pos_y_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_TILE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_acc) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TILE && out_free) begin
			out_pane_q <= pane_q;
			out_x_q    <= pos_x_q;
			out_y_q    <= pos_y_q;
			out_res_q  <= tile_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_pane_q;
	assign m_tdata  = {6'd0,
	                   out_res_q.row_ty, out_res_q.row_tx, out_res_q.row_ref,
	                   out_res_q.col_ty, out_res_q.col_tx, out_res_q.col_ref,
	                   out_y_q, out_x_q};

`ifndef SYNTHESIS
	// divider finishes only while the sequencer waits for it
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DIV))
		else $error("divider done outside wait state");

	// an accepted request starts on the X axis
	a_accept_starts_x: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> (state_q == ST_MUL && !axis_q))
		else $error("accepted request did not start X axis");

	// a held result is never overwritten by the next one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TILE && m_valid_q && !m_tready) |=>
		(state_q == ST_TILE && $stable(out_x_q) && $stable(out_y_q)))
		else $error("pending result overwritten");
`endif

endmodule

// ===== src/site_div.sv =====
// ----------------------------------------------------------------------------
// site_div
// Shared unsigned 32/16 restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module site_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [site_pkg::NUM_W-1:0]    num,
	input  logic [site_pkg::DEN_W-1:0]    den,
	output site_pkg::div_sts_t            sts,
	output logic [site_pkg::NUM_W-1:0]    quo
);

	logic [site_pkg::NUM_W-1:0]  num_q;
	logic [site_pkg::DEN_W-1:0]  den_q;
	logic [site_pkg::DEN_W-1:0]  rem_q;
	logic [site_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [site_pkg::DEN_W:0]    t1, t2, d17;
	logic                        ge1, ge2;
	logic [site_pkg::DEN_W-1:0]  r1, r2;

	always_comb begin
		d17 = {1'b0, den_q};
		t1  = {rem_q, num_q[site_pkg::NUM_W-1]};
		ge1 = t1 >= d17;
		r1  = ge1 ? site_pkg::DEN_W'(t1 - d17) : t1[site_pkg::DEN_W-1:0];
		t2  = {r1, num_q[site_pkg::NUM_W-2]};
		ge2 = t2 >= d17;
		r2  = ge2 ? site_pkg::DEN_W'(t2 - d17) : t2[site_pkg::DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == site_pkg::DCNT_W'(site_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[site_pkg::NUM_W-3:0], ge1, ge2};
			rem_q <= r2;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = num_q;

endmodule

// ===== src/site_tile.sv =====
// ----------------------------------------------------------------------------
// site_tile
// Tile change detection and edge-offset refresh coordinates.
// ----------------------------------------------------------------------------
module site_tile #(
	parameter int TILE_SHIFT = site_pkg::TILE_SHIFT_DEF
) (
	input  logic [site_pkg::POS_W-1:0] pos_x,
	input  logic [site_pkg::POS_W-1:0] pos_y,
	input  logic [site_pkg::POS_W-1:0] drawn_x,
	input  logic [site_pkg::POS_W-1:0] drawn_y,
	input  logic [1:0]                 dir_x,
	input  logic [1:0]                 dir_y,
	input  logic [site_pkg::OFF_W-1:0] x_off,
	input  logic [site_pkg::OFF_W-1:0] y_off,
	output site_pkg::res_t             res
);

	logic signed [site_pkg::POS_W-1:0] tx, ty, dtx, dty;
	logic signed [site_pkg::POS_W:0]   tx17, ty17;
	logic signed [site_pkg::POS_W:0]   ctx, cty, rtx, rty;
	logic                              col, row;

	always_comb begin
		tx   = $signed(pos_x) >>> TILE_SHIFT;
		ty   = $signed(pos_y) >>> TILE_SHIFT;
		dtx  = $signed(drawn_x) >>> TILE_SHIFT;
		dty  = $signed(drawn_y) >>> TILE_SHIFT;
		col  = tx != dtx;
		row  = ty != dty;
		tx17 = {tx[site_pkg::POS_W-1], tx};
		ty17 = {ty[site_pkg::POS_W-1], ty};
		ctx  = tx17 + (site_pkg::POS_W+1)'(site_pkg::edge_off(x_off, {1'b0, dir_x}));
		cty  = ty17 + (site_pkg::POS_W+1)'(site_pkg::edge_off(y_off, {1'b0, dir_y}));
		rtx  = tx17 + (site_pkg::POS_W+1)'(site_pkg::edge_off(x_off,
			site_pkg::ROW_BASE + {1'b0, dir_x}));
		rty  = ty17 + (site_pkg::POS_W+1)'(site_pkg::edge_off(y_off,
			site_pkg::ROW_BASE + {1'b0, dir_y}));

		res.col_ref = col;
		res.col_tx  = col ? ctx[site_pkg::TILE_W-1:0] : '0;
		res.col_ty  = col ? cty[site_pkg::TILE_W-1:0] : '0;
		res.row_ref = row;
		res.row_tx  = row ? rtx[site_pkg::TILE_W-1:0] : '0;
		res.row_ty  = row ? rty[site_pkg::TILE_W-1:0] : '0;
	end

endmodule
